// ===== hdl/heightmap_shading_intensity_defines.svh =====
// Assertion macros shared by the heightmap shading RTL.
// Included by hsi_core, which checks its own control logic; no other dependencies.
`ifndef HEIGHTMAP_SHADING_INTENSITY_DEFINES_SVH
`define HEIGHTMAP_SHADING_INTENSITY_DEFINES_SVH
`ifndef SYNTH
`define HSI_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("hsi assertion failed");
`define HSI_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("hsi assertion failed");
`else
`define HSI_ASSERT_SAME(lbl, ck, rs, ante, cons)
`define HSI_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

// ===== hdl/hsi_pkg.sv =====
// Shared types and constants for the heightmap shading block.
// No dependencies.
package hsi_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] REG_GRID_SPACING = 2'd0;
  localparam logic [1:0] REG_LIGHT_X      = 2'd1;
  localparam logic [1:0] REG_LIGHT_Y      = 2'd2;
  localparam logic [1:0] REG_LIGHT_Z      = 2'd3;

  localparam int DIV_STEPS  = 29;
  localparam int SQRT_STEPS = 15;

  typedef struct packed {
    logic        cmd;
    logic [6:0]  col;
    logic [6:0]  row;
    logic [15:0] height;
  } item_t;

  typedef struct packed {
    logic        [15:0] grid_spacing;
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;
  } cfg_t;

  // a2: squared component magnitude, q: squared vector length
  typedef struct packed {
    logic [32:0] a2;
    logic [33:0] q;
  } norm_req_t;

endpackage

// ===== hdl/hsi_fifo.sv =====
// Short item queue between the front end and the shading engine.
// Depends on hsi_pkg.
module hsi_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  hsi_pkg::item_t push_item,
  output logic          pop_valid,
  input  logic          pop_ready,
  output hsi_pkg::item_t pop_item
);

  localparam int DEPTH = 4;

  hsi_pkg::item_t entries [DEPTH];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 3'(DEPTH));
  assign pop_valid  = (count != 3'd0);
  assign pop_item   = entries[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + 2'd1;
      end
      if (do_pop) begin
        rp <= rp + 2'd1;
      end
      count <= count + 3'(do_push) - 3'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wp] <= push_item;
    end
  end

endmodule

// ===== hdl/hsi_norm.sv =====
// Shared unit-vector component unit: bit-serial divide, then bit-serial square root.
// Returns floor(sqrt(floor(a2 * 2^28 / q))); depends on hsi_pkg.
module hsi_norm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  hsi_pkg::norm_req_t   req,
  output logic                 done,
  output logic [14:0]          root
);

  typedef enum logic [1:0] {N_IDLE, N_DIV, N_SQRT} nstate_t;

  nstate_t     state;
  logic [33:0] q;
  logic [34:0] rem;
  logic [28:0] quo;
  logic [29:0] v;
  logic [29:0] res;
  logic [29:0] sbit;
  logic [4:0]  cnt;
  logic [29:0] trial;

  assign trial = res + sbit;
  assign root  = res[14:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      unique case (state)
        N_IDLE: begin
          done <= 1'b0;
          if (start) begin
            q     <= req.q;
            rem   <= 35'(req.a2);
            quo   <= '0;
            cnt   <= '0;
            state <= N_DIV;
          end
        end
        N_DIV: begin
          // one quotient bit per cycle, most significant first
          if (rem >= 35'(q)) begin
            rem <= (rem - 35'(q)) << 1;
            quo <= {quo[27:0], 1'b1};
          end else begin
            rem <= rem << 1;
            quo <= {quo[27:0], 1'b0};
          end
          if (cnt == 5'(hsi_pkg::DIV_STEPS - 1)) begin
            cnt   <= '0;
            state <= N_SQRT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        N_SQRT: begin
          if (cnt == 5'd0) begin
            v    <= 30'(quo);
            res  <= '0;
            sbit <= 30'(1) << 28;
            cnt  <= 5'd1;
          end else begin
            if (v >= trial) begin
              v   <= v - trial;
              res <= (res >> 1) + sbit;
            end else begin
              res <= res >> 1;
            end
            sbit <= sbit >> 2;
            if (cnt == 5'(hsi_pkg::SQRT_STEPS)) begin
              done  <= 1'b1;
              cnt   <= '0;
              state <= N_IDLE;
            end else begin
              cnt <= cnt + 5'd1;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/hsi_core.sv =====
// Shading engine: height memory, neighbor reads, normal sum, light dot product.
// Depends on hsi_pkg, hsi_norm and heightmap_shading_intensity_defines.svh.
`include "heightmap_shading_intensity_defines.svh"
module hsi_core #(
  parameter int MAP_BITS = 7
) (
  input  logic           clk,
  input  logic           rst,
  input  hsi_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  hsi_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_data
);

  localparam int AW = 2 * MAP_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SQUARE, S_NORM, S_NWAIT, S_DOT, S_FINAL
  } state_t;

  state_t state;

  logic [15:0]        mem [0:(1 << AW) - 1];
  logic [15:0]        rdata;
  logic [AW-1:0]      raddr;
  logic [MAP_BITS-1:0] qc;
  logic [MAP_BITS-1:0] qr;
  logic [MAP_BITS-1:0] ic;
  logic [MAP_BITS-1:0] ir;
  logic [2:0]         rcnt;
  logic [15:0]        h [5];
  logic [2:0]         vidx;
  logic [1:0]         comp;
  logic [1:0]         cnt;
  logic [1:0]         sel;
  logic [32:0]        sq [3];
  logic [32:0]        prod;
  logic [33:0]        q;
  logic signed [17:0] sum [3];
  logic signed [15:0] nv [3];
  logic signed [31:0] prod2;
  logic signed [33:0] d;

  logic signed [16:0] dn, de, ds, dw;
  logic signed [17:0] vx, vy, vz, vc;
  logic signed [17:0] vabs;
  logic [16:0]        mag;
  logic [33:0]        mag_sq;
  logic signed [15:0] rv;
  logic signed [15:0] val;
  logic signed [15:0] lsel;
  logic               store;
  logic               nstart;
  logic               ndone;
  logic [14:0]        nroot;
  hsi_pkg::norm_req_t nreq;
  logic signed [35:0] u;
  logic [43:0]        p;
  logic [7:0]         level;

  assign ic = MAP_BITS'(in_item.col);
  assign ir = MAP_BITS'(in_item.row);
  assign in_ready = (state == S_IDLE);

  // neighbor order: center, row+1, col+1, row-1, col-1
  always_comb begin
    case (rcnt)
      3'd0:    raddr = {qr, qc};
      3'd1:    raddr = {qr + MAP_BITS'(1), qc};
      3'd2:    raddr = {qr, qc + MAP_BITS'(1)};
      3'd3:    raddr = {qr - MAP_BITS'(1), qc};
      default: raddr = {qr, qc - MAP_BITS'(1)};
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && in_item.cmd == hsi_pkg::CMD_WRITE) begin
      mem[{ir, ic}] <= in_item.height;
    end
    if (state == S_READ) begin
      rdata <= mem[raddr];
    end
  end

  assign dn = $signed({1'b0, h[1]}) - $signed({1'b0, h[0]});
  assign de = $signed({1'b0, h[2]}) - $signed({1'b0, h[0]});
  assign ds = $signed({1'b0, h[3]}) - $signed({1'b0, h[0]});
  assign dw = $signed({1'b0, h[4]}) - $signed({1'b0, h[0]});

  always_comb begin
    vz = -$signed({2'b00, cfg.grid_spacing});
    case (vidx)
      3'd0: begin vx = {de[16], de};  vy = {dn[16], dn};  end
      3'd1: begin vx = {de[16], de};  vy = -{ds[16], ds}; end
      3'd2: begin vx = -{dw[16], dw}; vy = -{ds[16], ds}; end
      3'd3: begin vx = -{dw[16], dw}; vy = {dn[16], dn};  end
      default: begin
        vx = sum[0];
        vy = sum[1];
        vz = sum[2];
      end
    endcase
  end

  assign sel = (state == S_SQUARE) ? cnt : comp;

  always_comb begin
    case (sel)
      2'd0:    vc = vx;
      2'd1:    vc = vy;
      default: vc = vz;
    endcase
  end

  assign vabs   = vc[17] ? -vc : vc;
  assign mag    = vabs[16:0];
  assign mag_sq = mag * mag;

  assign nreq.a2 = sq[comp];
  assign nreq.q  = q;
  assign nstart  = (state == S_NORM) && (q != '0);
  assign store   = ((state == S_NORM) && (q == '0)) || ((state == S_NWAIT) && ndone);
  assign rv      = (state == S_NWAIT) ? $signed({1'b0, nroot}) : 16'sd0;
  assign val     = vc[17] ? -rv : rv;

  always_comb begin
    case (cnt)
      2'd0:    lsel = cfg.light_x;
      2'd1:    lsel = cfg.light_y;
      default: lsel = cfg.light_z;
    endcase
  end

  // (d + 1) * 127.5 as ((d + 2^28) * 255) >> 29, clamped
  assign u = {{2{d[33]}}, d} + 36'sd268435456;
  assign p = {u[35:0], 8'b0} - {8'b0, u[35:0]};
  always_comb begin
    if (u <= 36'sd0) begin
      level = 8'd0;
    end else if (|p[43:37]) begin
      level = 8'd255;
    end else begin
      level = p[36:29];
    end
  end

  hsi_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (nstart),
    .req   (nreq),
    .done  (ndone),
    .root  (nroot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rcnt      <= '0;
      vidx      <= '0;
      comp      <= '0;
      cnt       <= '0;
    end else begin
      if (out_valid && out_ready && state != S_FINAL) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_item.cmd == hsi_pkg::CMD_QUERY) begin
            qc    <= ic;
            qr    <= ir;
            rcnt  <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (rcnt != 3'd0) begin
            h[rcnt - 3'd1] <= rdata;
          end
          if (rcnt == 3'd5) begin
            vidx  <= '0;
            cnt   <= '0;
            q     <= '0;
            sum[0] <= '0;
            sum[1] <= '0;
            sum[2] <= '0;
            state <= S_SQUARE;
          end else begin
            rcnt <= rcnt + 3'd1;
          end
        end
        S_SQUARE: begin
          prod <= mag_sq[32:0];
          if (cnt != 2'd0) begin
            sq[cnt - 2'd1] <= prod;
            q <= q + 34'(prod);
          end
          if (cnt == 2'd3) begin
            comp  <= '0;
            state <= S_NORM;
          end else begin
            cnt <= cnt + 2'd1;
          end
        end
        S_NORM: begin
          if (q != '0) begin
            state <= S_NWAIT;
          end
        end
        S_NWAIT: begin
        end
        S_DOT: begin
          if (cnt != 2'd3) begin
            prod2 <= nv[cnt] * lsel;
          end
          if (cnt != 2'd0) begin
            d <= d + {{2{prod2[31]}}, prod2};
          end
          if (cnt == 2'd3) begin
            state <= S_FINAL;
          end else begin
            cnt <= cnt + 2'd1;
          end
        end
        S_FINAL: begin
          if (!out_valid || out_ready) begin
            out_data  <= level;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (store) begin
        if (vidx == 3'd4) begin
          nv[comp] <= val;
        end else begin
          sum[comp] <= sum[comp] + {{2{val[15]}}, val};
        end
        if (comp == 2'd2) begin
          cnt <= '0;
          if (vidx == 3'd4) begin
            d     <= '0;
            state <= S_DOT;
          end else begin
            vidx  <= vidx + 3'd1;
            q     <= '0;
            state <= S_SQUARE;
          end
        end else begin
          comp  <= comp + 2'd1;
          state <= S_NORM;
        end
      end
    end
  end

  `HSI_ASSERT_SAME(a_start_in_norm, clk, rst, nstart, state == S_NORM)
  `HSI_ASSERT_SAME(a_done_when_waiting, clk, rst, ndone, state == S_NWAIT)
  `HSI_ASSERT_SAME(a_take_only_idle, clk, rst, in_valid && in_ready, state == S_IDLE)
  `HSI_ASSERT_NEXT(a_final_loads_out, clk, rst,
                   state == S_FINAL && (!out_valid || out_ready), out_valid)

endmodule

// ===== hdl/heightmap_shading_intensity.sv =====
// Channel    Dir  Width  Contents
// s_axis     in   32+1   tuser: cmd; tdata: col, row, height
// m_axis     out  8      tdata: intensity
// cfg        in   2+16   register index, write data
// A height write leaves the queue whenever the engine is idle. A query takes
// five memory reads, then fifteen unit-vector components on the shared
// divide/square-root unit (each: divide, root, handoff), then a three-step dot
// product. Up to four items queue in front of the engine; a finished result
// holds in the output register until taken, and the engine stalls on the next
// result until then, while the queue keeps taking items. Reset is synchronous.
module heightmap_shading_intensity #(
  parameter int MAP_BITS = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // col[6:0], row[13:7], height[29:14], zero pad
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // intensity[7:0]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  hsi_pkg::cfg_t  cfg;
  hsi_pkg::item_t in_item;
  hsi_pkg::item_t q_item;
  logic           q_valid;
  logic           q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_spacing <= 16'd256;
      cfg.light_x      <= 16'sd9459;
      cfg.light_y      <= 16'sd9459;
      cfg.light_z      <= -16'sd9459;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        hsi_pkg::REG_GRID_SPACING: cfg.grid_spacing <= cfg_data;
        hsi_pkg::REG_LIGHT_X:      cfg.light_x      <= $signed(cfg_data);
        hsi_pkg::REG_LIGHT_Y:      cfg.light_y      <= $signed(cfg_data);
        hsi_pkg::REG_LIGHT_Z:      cfg.light_z      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign in_item.cmd    = s_axis_tuser;
  assign in_item.col    = s_axis_tdata[6:0];
  assign in_item.row    = s_axis_tdata[13:7];
  assign in_item.height = s_axis_tdata[29:14];

  hsi_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_axis_tvalid),
    .push_ready (s_axis_tready),
    .push_item  (in_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  hsi_core #(
    .MAP_BITS (MAP_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for heightmap_shading_intensity: writes small patches of heights,
// queries the shaded cells and compares each intensity with a built-in predictor.
// Depends on hsi_pkg and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE = 128;
  localparam int SETTLE = 800;     // one query through the engine plus margin
  localparam int WATCHDOG = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_data = '0;

  heightmap_shading_intensity i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0]        heights [SIDE*SIDE];
  logic [15:0]        spacing;
  logic signed [15:0] lx, ly, lz;

  hsi_pkg::item_t beats_to_send[$];
  logic [7:0]  intensity_due[$];
  int          shaded_cells[$];
  int          errors = 0;
  int          quiet_cycles = 0;
  bit          noisy = 1'b1;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits >>= 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v -= res + bits;
        res = (res >> 1) + bits;
      end else begin
        res >>= 1;
      end
      bits >>= 2;
    end
    return res;
  endfunction

  function automatic longint unit_part(longint c, longint unsigned q);
    longint unsigned a, r;
    if (q == 0) return 0;
    a = (c < 0) ? -c : c;
    r = isqrt(((a * a) << 28) / q);
    return (c < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void add_unit(input longint a, b, c, inout longint acc[3]);
    longint unsigned q;
    q = a * a + b * b + c * c;
    acc[0] += unit_part(a, q);
    acc[1] += unit_part(b, q);
    acc[2] += unit_part(c, q);
  endfunction

  function automatic logic [7:0] lambert(int col, int row);
    longint h0, dn, de, ds, dw, s, d, u, lev;
    longint sum[3], n[3];
    h0 = heights[row*SIDE + col];
    dn = longint'(heights[((row+1)%SIDE)*SIDE + col]) - h0;
    de = longint'(heights[row*SIDE + (col+1)%SIDE]) - h0;
    ds = longint'(heights[((row+SIDE-1)%SIDE)*SIDE + col]) - h0;
    dw = longint'(heights[row*SIDE + (col+SIDE-1)%SIDE]) - h0;
    s = spacing;
    sum = '{0, 0, 0};
    n = '{0, 0, 0};
    add_unit(de, dn, -s, sum);
    add_unit(de, -ds, -s, sum);
    add_unit(-dw, -ds, -s, sum);
    add_unit(-dw, dn, -s, sum);
    add_unit(sum[0], sum[1], sum[2], n);
    d = n[0] * longint'(lx) + n[1] * longint'(ly) + n[2] * longint'(lz);
    u = d + (64'sd1 << 28);
    if (u <= 0) return 8'd0;
    lev = (u * 255) >>> 29;
    return (lev > 255) ? 8'd255 : lev[7:0];
  endfunction

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    errors++;
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
  endtask

  // driver
  always @(posedge clk) begin
    hsi_pkg::item_t it;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        it.cmd = s_axis_tuser;
        it.col = s_axis_tdata[6:0];
        it.row = s_axis_tdata[13:7];
        it.height = s_axis_tdata[29:14];
        if (it.cmd == hsi_pkg::CMD_WRITE) heights[it.row*SIDE + it.col] = it.height;
        else intensity_due.push_back(lambert(it.col, it.row));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (beats_to_send.size() > 0 && !(noisy && $urandom_range(99) < 26)) begin
          it = beats_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= it.cmd;
          s_axis_tdata <= {2'b00, it.height, it.row, it.col};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (intensity_due.size() == 0) report("unexpected beat", m_axis_tdata, 8'd0);
        else if (m_axis_tdata !== intensity_due[0])
          report("intensity", m_axis_tdata, intensity_due.pop_front());
        else void'(intensity_due.pop_front());
      end
      m_axis_tready <= !(noisy && $urandom_range(99) < 26);
    end
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_write(int col, int row, logic [15:0] h);
    hsi_pkg::item_t it;
    it.cmd = hsi_pkg::CMD_WRITE;
    it.col = col % SIDE;
    it.row = row % SIDE;
    it.height = h;
    beats_to_send.push_back(it);
  endtask

  task automatic push_query(int col, int row);
    hsi_pkg::item_t it;
    it.cmd = hsi_pkg::CMD_QUERY;
    it.col = col;
    it.row = row;
    it.height = 16'($urandom);
    beats_to_send.push_back(it);
    shaded_cells.push_back(row*SIDE + col);
  endtask

  // center height plus four neighbours, then the query; kind picks the terrain
  task automatic patch(int col, int row, int kind, logic [15:0] base);
    logic [15:0] h[5];
    int dc[5], dr[5];
    dc = '{0, 0, 1, 0, SIDE-1};
    dr = '{0, 1, 0, SIDE-1, 0};
    foreach (h[k]) begin
      case (kind)
        0: h[k] = 16'($urandom);
        1: h[k] = base + 16'($urandom_range(1024)) - 16'd512;
        default: h[k] = base;
      endcase
    end
    for (int k = 1; k < 5; k++) push_write(col + dc[k], row + dr[k], h[k]);
    push_write(col, row, h[0]);
    push_query(col, row);
  endtask

  task automatic random_items(int count);
    int goal, pick;
    goal = beats_to_send.size() + count;
    while (beats_to_send.size() < goal) begin
      pick = $urandom_range(99);
      if (pick < 25 && shaded_cells.size() > 0) begin
        pick = shaded_cells[$urandom_range(shaded_cells.size()-1)];
        push_query(pick % SIDE, pick / SIDE);
      end else if (pick < 32) begin
        // stray write that completes no patch
        push_write($urandom_range(SIDE-1), $urandom_range(SIDE-1), 16'($urandom));
      end else begin
        patch($urandom_range(SIDE-1), $urandom_range(SIDE-1), $urandom_range(2),
              16'($urandom));
      end
    end
  endtask

  task automatic settle();
    while (beats_to_send.size() != 0 || s_axis_tvalid || intensity_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] gs, logic [15:0] x, logic [15:0] y,
                          logic [15:0] z);
    logic [15:0] vals[4];
    vals = '{gs, x, y, z};
    for (int k = 0; k < 4; k++) begin
      cfg_we <= 1'b1;
      cfg_addr <= 2'(k);
      cfg_data <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    spacing = gs;
    lx = x;
    ly = y;
    lz = z;
  endtask

  initial begin
    spacing = 16'd256;
    lx = 16'sd9459;
    ly = 16'sd9459;
    lz = -16'sd9459;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: flat ground, corner wrap, extreme slopes
    patch(0, 0, 2, 16'd0);
    patch(SIDE-1, SIDE-1, 2, 16'hffff);
    push_write(SIDE-1, SIDE-1, 16'd0);
    push_query(SIDE-1, SIDE-1);
    push_write(0, SIDE-1, 16'hffff);
    push_query(SIDE-1, SIDE-1);
    patch(64, 63, 0, 16'd0);
    patch(5, SIDE-1, 1, 16'h8000);
    random_items(100);
    settle();

    set_regs(16'd1, 16'sd16384, 16'sd0, 16'sd0);
    push_query(0, 0);
    push_query(SIDE-1, SIDE-1);
    random_items(60);
    settle();

    set_regs(16'hffff, -16'sd16384, -16'sd16384, -16'sd16384);
    push_query(0, 0);
    random_items(60);
    settle();

    // zero spacing: flat patches normalize to the zero vector
    set_regs(16'd0, 16'sd0, 16'sd0, 16'sd16384);
    patch(40, 40, 2, 16'h1234);
    push_query(0, 0);
    random_items(40);
    settle();

    // light out of unit range, no idling on either side
    noisy = 1'b0;
    set_regs(16'($urandom_range(65535, 1)), 16'sh7fff, -16'sh8000, 16'sh7fff);
    random_items(100);
    settle();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
